### rtl/core/go_to_goal_heading_controller_top_macros.svh
// Assertion macros used by the checker file.
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_TOP_MACROS_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define GTG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define GTG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/core/gtg_pkg.sv
// Shared types, constants and tables of the heading controller.
package gtg_pkg;
	localparam int CordicSteps = 16;
	localparam int StepW = 5;
	localparam logic signed [31:0] PiQ29 = 32'sd1686629713;
	localparam logic signed [15:0] PiQ13 = 16'sd25736;

	typedef enum logic [2:0] {
		REG_GOAL_X = 3'd0, REG_GOAL_Y = 3'd1, REG_GOAL_TOL = 3'd2,
		REG_HEAD_TOL = 3'd3, REG_TURN_RATE = 3'd4, REG_DRIVE_RATE = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIST, ST_YAW, ST_BEAR, ST_DECIDE, ST_OUT
	} state_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] turn_cmd;
		logic signed [15:0] drive_cmd;
		logic at_goal;
	} out_item_t;

	typedef struct packed {
		logic [2:0] idx;
		logic [31:0] data;
	} cfg_item_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} cordic_ctl_t;

	// Arctangent of 2^-i in Q.29
	function automatic logic signed [31:0] atan_q29(input logic [StepW-1:0] i);
		case (i)
			5'd0: atan_q29 = 32'sd421657428;
			5'd1: atan_q29 = 32'sd248918915;
			5'd2: atan_q29 = 32'sd131521918;
			5'd3: atan_q29 = 32'sd66762579;
			5'd4: atan_q29 = 32'sd33510843;
			5'd5: atan_q29 = 32'sd16771758;
			5'd6: atan_q29 = 32'sd8387925;
			5'd7: atan_q29 = 32'sd4194219;
			5'd8: atan_q29 = 32'sd2097141;
			5'd9: atan_q29 = 32'sd1048575;
			5'd10: atan_q29 = 32'sd524288;
			5'd11: atan_q29 = 32'sd262144;
			5'd12: atan_q29 = 32'sd131072;
			5'd13: atan_q29 = 32'sd65536;
			5'd14: atan_q29 = 32'sd32768;
			5'd15: atan_q29 = 32'sd16384;
			5'd16: atan_q29 = 32'sd8192;
			5'd17: atan_q29 = 32'sd4096;
			5'd18: atan_q29 = 32'sd2048;
			5'd19: atan_q29 = 32'sd1024;
			5'd20: atan_q29 = 32'sd512;
			5'd21: atan_q29 = 32'sd256;
			5'd22: atan_q29 = 32'sd128;
			5'd23: atan_q29 = 32'sd64;
			default: atan_q29 = 32'sd0;
		endcase
	endfunction
endpackage

### rtl/core/gtg_cordic.sv
// Iterative CORDIC vectoring unit: one rotation per cycle, atan2 in Q3.13.
module gtg_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [39:0] y_in,
	input logic signed [39:0] x_in,
	output gtg_pkg::cordic_ctl_t ctl,
	output logic signed [15:0] angle
);
	import gtg_pkg::*;

	logic signed [41:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [StepW-1:0] i_q;
	logic busy_q, done_q;
	logic signed [41:0] xs, ys;
	logic signed [31:0] zr;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign zr = z_q + 32'sd32768;
	assign angle = zr[31:16];
	assign ctl = '{start: start, busy: busy_q, done: done_q};

	// Quadrant fold on start, then rotations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (x_in == 40'sd0 && y_in == 40'sd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == StepW'(CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in < 0) begin
				x_q <= -42'(x_in);
				y_q <= -42'(y_in);
				z_q <= (y_in >= 0) ? PiQ29 : -PiQ29;
			end else begin
				x_q <= 42'(x_in);
				y_q <= 42'(y_in);
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q29(i_q);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q29(i_q);
			end
		end
	end
endmodule

### rtl/core/gtg_dist.sv
// Squared distance compare, one 16-bit digit of the multiplier per cycle.
module gtg_dist (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] adx,
	input logic [31:0] ady,
	input logic [30:0] tol,
	output logic done,
	output logic near_goal
);
	// acc = dx^2 + dy^2 - tol^2, built from six 32x16 partial products
	logic signed [67:0] acc_q;
	logic [2:0] k_q;
	logic busy_q, done_q;
	logic [31:0] a;
	logic [15:0] b;
	logic [47:0] pp;
	logic [67:0] ppw;

	always_comb begin
		case (k_q)
			3'd0: begin a = adx; b = adx[15:0]; end
			3'd1: begin a = adx; b = adx[31:16]; end
			3'd2: begin a = ady; b = ady[15:0]; end
			3'd3: begin a = ady; b = ady[31:16]; end
			3'd4: begin a = {1'b0, tol}; b = tol[15:0]; end
			3'd5: begin a = {1'b0, tol}; b = {1'b0, tol[30:16]}; end
			default: begin a = '0; b = '0; end
		endcase
		pp = a * b;
		ppw = k_q[0] ? {4'd0, pp, 16'd0} : {20'd0, pp};
	end

	assign done = done_q;
	assign near_goal = acc_q <= 0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				k_q <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 1'b1;
				if (k_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) acc_q <= '0;
		else if (busy_q) acc_q <= k_q[2] ? acc_q - $signed(ppw) : acc_q + $signed(ppw);
	end
endmodule

### rtl/core/go_to_goal_heading_controller_top.sv
// Top level of the go-to-goal heading controller.
// Usage:
// - cfg channel (cfg_valid/cfg_ready, idx + data) writes goal_x, goal_y,
//   goal_tolerance, heading_tolerance, turn_rate, drive_rate; always ready.
// - in channel takes one odometry item (position, quaternion).
// - out channel returns one command item per input item.
// In the turn/drive case an item passes a six-digit multiply for the distance
// test and two 16-step runs of the shared CORDIC unit; when the distance test
// reaches the goal the CORDIC runs are skipped, and once the goal is latched
// the distance test is skipped too.
// A new item is taken only in the idle state, after the last one is done.
// One item is in work at a time.
// A result waits in the output register; meanwhile the next item is taken
// and computed, then held until the register frees, so a stalled receiver
// ends up stalling the input.
// Reset clears the latched at_goal flag, drops out_valid and loads the
// register defaults.
module go_to_goal_heading_controller_top (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input gtg_pkg::cfg_item_t cfg,
	input logic in_valid,
	output logic in_ready,
	input gtg_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output gtg_pkg::out_item_t out_item
);
	import gtg_pkg::*;

	logic signed [31:0] goal_x_q, goal_y_q;
	logic [30:0] goal_tol_q;
	logic [14:0] head_tol_q;
	logic signed [15:0] turn_rate_q, drive_rate_q;
	logic reached_q;
	state_t state_q, state_d;
	in_item_t item_q;
	logic signed [31:0] dx_q, dy_q;
	logic signed [15:0] yaw_q, bear_q;
	out_item_t res_q, out_q;
	logic out_valid_q;
	logic out_free;

	// Saturated differences
	logic signed [32:0] dxw, dyw;
	logic signed [31:0] dxs, dys;
	assign dxw = 33'(goal_x_q) - 33'(item_q.pos_x);
	assign dyw = 33'(goal_y_q) - 33'(item_q.pos_y);
	assign dxs = (dxw[32] != dxw[31]) ? {dxw[32], {31{~dxw[32]}}} : dxw[31:0];
	assign dys = (dyw[32] != dyw[31]) ? {dyw[32], {31{~dyw[32]}}} : dyw[31:0];

	// Yaw vector terms
	logic signed [39:0] siny, cosy;
	always_comb begin
		siny = 40'(($signed(item_q.quat_w) * $signed(item_q.quat_z)
			+ $signed(item_q.quat_x) * $signed(item_q.quat_y))) <<< 1;
		cosy = 40'sd268435456 - (40'(($signed(item_q.quat_y) * $signed(item_q.quat_y)
			+ $signed(item_q.quat_z) * $signed(item_q.quat_z))) <<< 1);
	end

	logic dist_start, dist_done, dist_in;
	logic [31:0] adx, ady;
	assign adx = dx_q[31] ? 32'(-33'(dx_q)) : dx_q;
	assign ady = dy_q[31] ? 32'(-33'(dy_q)) : dy_q;

	gtg_dist u_dist (.clk, .arst_n, .start(dist_start), .adx, .ady,
		.tol(goal_tol_q), .done(dist_done), .near_goal(dist_in));

	logic cor_start;
	logic signed [39:0] cor_y, cor_x;
	cordic_ctl_t cor_ctl;
	logic signed [15:0] cor_ang;
	assign cor_y = (state_q == ST_YAW) ? siny : 40'(dy_q);
	assign cor_x = (state_q == ST_YAW) ? cosy : 40'(dx_q);

	gtg_cordic u_cordic (.clk, .arst_n, .start(cor_start), .y_in(cor_y), .x_in(cor_x),
		.ctl(cor_ctl), .angle(cor_ang));

	// Heading error wrap and decision
	logic signed [16:0] err, errw, mag;
	logic signed [15:0] neg_turn;
	always_comb begin
		err = 17'(yaw_q) - 17'(bear_q);
		errw = err;
		if (err > 17'(PiQ13)) errw = err - 17'(2 * PiQ13);
		if (err < -17'(PiQ13)) errw = err + 17'(2 * PiQ13);
		mag = errw[16] ? -errw : errw;
		neg_turn = (turn_rate_q == 16'sh8000) ? 16'sh7fff : -turn_rate_q;
	end

	logic started_q;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;

	// Sequencer next state
	always_comb begin
		state_d = state_q;
		dist_start = 1'b0;
		cor_start = 1'b0;
		case (state_q)
			ST_IDLE: if (in_valid && in_ready) state_d = ST_DIST;
			ST_DIST: begin
				dist_start = !started_q;
				if (dist_done) state_d = (reached_q || dist_in) ? ST_OUT : ST_YAW;
				if (reached_q) state_d = ST_OUT;
			end
			ST_YAW: begin
				cor_start = !started_q;
				if (cor_ctl.done) state_d = ST_BEAR;
			end
			ST_BEAR: begin
				cor_start = !started_q;
				if (cor_ctl.done) state_d = ST_DECIDE;
			end
			ST_DECIDE: state_d = ST_OUT;
			// hold the finished item until the output register frees
			ST_OUT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			reached_q <= 1'b0;
			out_valid_q <= 1'b0;
			goal_x_q <= '0;
			goal_y_q <= '0;
			goal_tol_q <= 31'd6554;
			head_tol_q <= 15'd715;
			turn_rate_q <= 16'sd2048;
			drive_rate_q <= -16'sd4096;
		end else begin
			state_q <= state_d;
			started_q <= (state_d == state_q) && (state_q != ST_IDLE);
			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (state_q == ST_DIST && dist_done && dist_in) reached_q <= 1'b1;
			if (cfg_valid) begin
				case (reg_idx_t'(cfg.idx))
					REG_GOAL_X: goal_x_q <= cfg.data;
					REG_GOAL_Y: goal_y_q <= cfg.data;
					REG_GOAL_TOL: goal_tol_q <= cfg.data[30:0];
					REG_HEAD_TOL: head_tol_q <= cfg.data[14:0];
					REG_TURN_RATE: turn_rate_q <= cfg.data[15:0];
					REG_DRIVE_RATE: drive_rate_q <= cfg.data[15:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_q <= in_item;
		if (state_q == ST_IDLE) begin
			dx_q <= dxs;
			dy_q <= dys;
		end
		if (state_q == ST_DIST) begin
			dx_q <= dxs;
			dy_q <= dys;
			res_q <= '{turn_cmd: '0, drive_cmd: '0, at_goal: 1'b1};
		end
		if (state_q == ST_YAW && cor_ctl.done) yaw_q <= cor_ang;
		if (state_q == ST_BEAR && cor_ctl.done) bear_q <= cor_ang;
		if (state_q == ST_DECIDE) begin
			res_q.at_goal <= 1'b0;
			if (mag > 17'($unsigned(head_tol_q))) begin
				res_q.turn_cmd <= errw[16] ? neg_turn : turn_rate_q;
				res_q.drive_cmd <= '0;
			end else begin
				res_q.turn_cmd <= '0;
				res_q.drive_cmd <= drive_rate_q;
			end
		end
		if (state_q == ST_OUT && out_free) out_q <= res_q;
	end
endmodule

### rtl/core/gtg_checker.sv
// Port-level checker for the heading controller, bound to the top level.
`include "go_to_goal_heading_controller_top_macros.svh"
module gtg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input gtg_pkg::out_item_t out_item
);
	logic in_take, out_stall, cmds_zero, one_cmd;
	assign in_take = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign cmds_zero = out_item.turn_cmd == 16'sd0 && out_item.drive_cmd == 16'sd0;
	assign one_cmd = out_item.turn_cmd == 16'sd0 || out_item.drive_cmd == 16'sd0;

	`GTG_ASSERT_NXT(a_one_at_time, clk, arst_n, in_take, !in_ready)
	`GTG_ASSERT_NXT(a_out_hold, clk, arst_n, out_stall, out_valid && $stable(out_item))
	`GTG_ASSERT_IMP(a_goal_zero, clk, arst_n, out_valid && out_item.at_goal, cmds_zero)
	`GTG_ASSERT_IMP(a_one_cmd, clk, arst_n, out_valid, one_cmd)
endmodule

bind go_to_goal_heading_controller_top gtg_checker u_gtg_checker (.clk, .arst_n,
	.in_valid, .in_ready, .out_valid, .out_ready, .out_item);
